FILE: rtl/assert_macros.svh
// assertion helpers for the sort check block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CSORT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CSORT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/csort_pkg.sv
`timescale 1ns / 1ps
package csort_pkg;

  localparam int MAX_WORD_LEN  = 32;
  localparam int ALPHABET_SIZE = 26;

  localparam int CODE_W  = 5;
  localparam int RANK_W  = 5;
  localparam int ADDR_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int POS_W   = $clog2(MAX_WORD_LEN + 1);

  localparam int TABLE_LOW_W  = 60;
  localparam int TABLE_MID_W  = 60;
  localparam int TABLE_HIGH_W = 10;
  localparam int TABLE_BITS   = TABLE_LOW_W + TABLE_MID_W + TABLE_HIGH_W;
  localparam int CFG_DATA_W   = 60;
  localparam int CFG_IDX_W    = 2;

  localparam logic [RANK_W-1:0] RANK_OUTSIDE = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANK_LOW,
    REG_RANK_MIDDLE,
    REG_RANK_HIGH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DEC_UNDECIDED,
    DEC_PRECEDES,
    DEC_FOLLOWS
  } decision_t;

  typedef struct packed {
    logic [TABLE_LOW_W-1:0]  low;
    logic [TABLE_MID_W-1:0]  middle;
    logic [TABLE_HIGH_W-1:0] high;
  } rank_table_t;

  // one letter as handed from the front to the back
  typedef struct packed {
    logic [CODE_W-1:0] cur_code;
    logic [CODE_W-1:0] prev_code;
    logic              compare;
    logic              word_end;
    logic              list_end;
    logic              len_ge;
    logic              too_long;
  } word_item_t;

  typedef struct packed {
    logic full;
    logic almost_full;
    logic empty;
  } queue_status_t;

  function automatic logic [RANK_W-1:0] rank_of(input logic [CODE_W-1:0] code,
                                               input rank_table_t tbl);
    logic [TABLE_BITS-1:0] flat;
    logic [7:0]            base;
    flat = {tbl.high, tbl.middle, tbl.low};
    base = 8'(code) * 8'(RANK_W);
    if (code >= CODE_W'(ALPHABET_SIZE)) begin
      return RANK_OUTSIDE;
    end
    return flat[base +: RANK_W];
  endfunction

endpackage

FILE: rtl/csort_if.sv
`timescale 1ns / 1ps
interface csort_in_if;
  logic                             valid;
  logic                             ready;
  logic [csort_pkg::CODE_W-1:0]     letter;
  logic                             word_end;
  logic                             list_end;

  modport source (output valid, letter, word_end, list_end, input ready);
  modport sink (input valid, letter, word_end, list_end, output ready);
endinterface

interface csort_out_if;
  logic valid;
  logic ready;
  logic pair_in_order;
  logic list_in_order;
  logic word_too_long;
  logic list_done;

  modport source (output valid, pair_in_order, list_in_order, word_too_long, list_done,
                  input ready);
  modport sink (input valid, pair_in_order, list_in_order, word_too_long, list_done,
                output ready);
endinterface

FILE: rtl/csort_front.sv
`timescale 1ns / 1ps
module csort_front (
  input  logic                      clk,
  input  logic                      rst,
  csort_in_if.sink                  letters,
  input  csort_pkg::queue_status_t  q_status,
  output logic                      push,
  output csort_pkg::word_item_t     push_item
);
  import csort_pkg::*;

  logic [CODE_W-1:0] prev_buf [MAX_WORD_LEN];
  logic [CODE_W-1:0] rd_data;

  logic [POS_W-1:0] letter_position;
  logic [POS_W-1:0] previous_length;
  logic             overflow_seen;

  logic             s1_valid;
  word_item_t       s1_item;

  logic             accept;
  logic             pos_in_buf;
  logic [POS_W-1:0] cur_len;
  logic [ADDR_W-1:0] addr;

  // leave room for the letter already in the stage register
  assign letters.ready = !q_status.full && !(s1_valid && q_status.almost_full);
  assign accept        = letters.valid && letters.ready;

  assign pos_in_buf = letter_position < POS_W'(MAX_WORD_LEN);
  assign cur_len    = pos_in_buf ? letter_position + POS_W'(1) : letter_position;
  assign addr       = letter_position[ADDR_W-1:0];

  // old letter is read out as the new one goes in
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= prev_buf[addr];
      if (pos_in_buf) begin
        prev_buf[addr] <= letters.letter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_position <= '0;
      previous_length <= '0;
      overflow_seen   <= 1'b0;
      s1_valid        <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (letters.word_end) begin
          letter_position <= '0;
          overflow_seen   <= 1'b0;
          previous_length <= letters.list_end ? '0 : cur_len;
        end else begin
          letter_position <= cur_len;
          overflow_seen   <= overflow_seen || !pos_in_buf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.cur_code  <= letters.letter;
      s1_item.prev_code <= '0;
      s1_item.compare   <= pos_in_buf && (letter_position < previous_length);
      s1_item.word_end  <= letters.word_end;
      s1_item.list_end  <= letters.list_end;
      s1_item.len_ge    <= cur_len >= previous_length;
      s1_item.too_long  <= overflow_seen || !pos_in_buf;
    end
  end

  always_comb begin
    push_item           = s1_item;
    push_item.prev_code = rd_data;
  end

  assign push = s1_valid;

endmodule

FILE: rtl/csort_queue.sv
`timescale 1ns / 1ps
module csort_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  csort_pkg::word_item_t     push_item,
  input  logic                      pop,
  output csort_pkg::word_item_t     pop_item,
  output csort_pkg::queue_status_t  status
);
  import csort_pkg::*;

  word_item_t         slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign pop_item           = slots[rd_ptr];
  assign status.full        = count == Q_CNT_W'(QUEUE_DEPTH);
  assign status.almost_full = count >= Q_CNT_W'(QUEUE_DEPTH - 1);
  assign status.empty       = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/csort_back.sv
`timescale 1ns / 1ps
module csort_back (
  input  logic                      clk,
  input  logic                      rst,
  input  csort_pkg::rank_table_t    ranks,
  input  csort_pkg::queue_status_t  q_status,
  input  csort_pkg::word_item_t     item,
  output logic                      pop,
  csort_out_if.source               results
);
  import csort_pkg::*;

  decision_t         decision;
  decision_t         decision_next;
  logic              all_ordered;
  logic [RANK_W-1:0] rank_cur;
  logic [RANK_W-1:0] rank_prev;
  logic              pair_ok;
  logic              list_ok;

  logic              out_valid;
  logic              out_pair;
  logic              out_list;
  logic              out_long;
  logic              out_done;

  assign pop = !q_status.empty && (!out_valid || results.ready);

  assign rank_cur  = rank_of(item.cur_code, ranks);
  assign rank_prev = rank_of(item.prev_code, ranks);

  always_comb begin
    decision_next = decision;
    if (item.compare && decision == DEC_UNDECIDED) begin
      if (rank_cur < rank_prev) begin
        decision_next = DEC_PRECEDES;
      end else if (rank_cur > rank_prev) begin
        decision_next = DEC_FOLLOWS;
      end
    end
    // a list's first word sees a zero previous length, so it passes
    unique case (decision_next)
      DEC_PRECEDES: pair_ok = 1'b0;
      DEC_FOLLOWS:  pair_ok = 1'b1;
      default:      pair_ok = item.len_ge;
    endcase
    list_ok = all_ordered && pair_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decision    <= DEC_UNDECIDED;
      all_ordered <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        if (item.word_end) begin
          decision    <= DEC_UNDECIDED;
          all_ordered <= item.list_end ? 1'b1 : list_ok;
          out_valid   <= 1'b1;
        end else begin
          decision <= decision_next;
          if (results.ready) begin
            out_valid <= 1'b0;
          end
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.word_end) begin
      out_pair <= pair_ok;
      out_list <= list_ok;
      out_long <= item.too_long;
      out_done <= item.list_end;
    end
  end

  assign results.valid         = out_valid;
  assign results.pair_in_order = out_pair;
  assign results.list_in_order = out_list;
  assign results.word_too_long = out_long;
  assign results.list_done     = out_done;

endmodule

FILE: rtl/custom_alphabet_sort_check_top.sv
`timescale 1ns / 1ps
// Checks that a list of words is in order under a programmable letter ranking.
// letters: one letter code a word per accepted transfer, with word_end on the last
//   letter of each word and list_end (read only with word_end) on the list's last word.
// results: one word per finished word: pair_in_order, list_in_order, word_too_long
//   and list_done, in input order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 low, 1 middle,
//   2 high rank table); write only while no word is in flight.
// A word_end letter passes the stage register and queue into the result register.
// Throughput: unless stalled, one letter per cycle; the previous-word buffer does
//   one read and at most one write per letter; the back end ranks one letter per cycle.
// Words longer than 32 letters are compared on their first 32 and flagged.
// Reset clears the position, length, order and queue state and drops any pending
//   result; the rank tables return to zero. The buffer needs no clearing.
// When results is stalled, the result holds, the four-entry queue fills and then
//   letters.ready drops; letters keep flowing while a result waits.
module custom_alphabet_sort_check_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [csort_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csort_pkg::CFG_DATA_W-1:0]    cfg_data,
  csort_in_if.sink                            letters,
  csort_out_if.source                         results
);
  import csort_pkg::*;

  rank_table_t   ranks;
  queue_status_t q_status;
  word_item_t    push_item;
  word_item_t    pop_item;
  logic          push;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      ranks <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANK_LOW:    ranks.low    <= cfg_data[TABLE_LOW_W-1:0];
        REG_RANK_MIDDLE: ranks.middle <= cfg_data[TABLE_MID_W-1:0];
        REG_RANK_HIGH:   ranks.high   <= cfg_data[TABLE_HIGH_W-1:0];
        default:         ranks        <= ranks;
      endcase
    end
  end

  csort_front u_front (
    .clk       (clk),
    .rst       (rst),
    .letters   (letters),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  csort_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  csort_back u_back (
    .clk      (clk),
    .rst      (rst),
    .ranks    (ranks),
    .q_status (q_status),
    .item     (pop_item),
    .pop      (pop),
    .results  (results)
  );

endmodule

FILE: rtl/csort_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csort_checker (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic res_pair,
  input logic res_list,
  input logic res_long,
  input logic res_done
);

  // a stalled result word holds
  `CSORT_ASSERT(a_hold, res_valid && !res_ready |=> res_valid && $stable({res_pair, res_list, res_long, res_done}), "result changed while stalled")

  // nothing is pending right after reset
  `CSORT_ASSERT_ALWAYS(a_reset, rst |=> !res_valid, "result valid after reset")

  // a bad pair always spoils the list flag
  `CSORT_ASSERT(a_list_pair, res_valid && !res_pair |-> !res_list, "list in order with bad pair")

endmodule

bind custom_alphabet_sort_check_top csort_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_pair  (results.pair_in_order),
  .res_list  (results.list_in_order),
  .res_long  (results.word_too_long),
  .res_done  (results.list_done)
);
